// ===== hw/rtl/ski_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the servo keyframe interpolator.
package ski_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_START = 2'd2,
    OP_SET   = 2'd3
  } op_t;

  localparam int unsigned POS_W  = 8;
  localparam int unsigned OFS_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned SID_W  = 4;
  localparam logic [31:0] MAP_RESET = 32'h7654_3210;

  typedef struct packed {
    op_t              op;
    logic             arm;
    logic [1:0]       channel;
    logic [OFS_W-1:0] start_offset;
    logic [OFS_W-1:0] stop_offset;
    logic [POS_W-1:0] target;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DIV,
    ST_EMIT,
    ST_FLAGS
  } back_state_t;

endpackage

// ===== hw/rtl/servo_keyframe_interpolator.sv =====
`timescale 1ns / 1ps
// A tick walks the channels in turn, and an interpolating channel waits on the serial
// divider (24-bit dividend); then the tick's results drain.
// Other commands are executed by the back end from idle; up to four commands queue in front.
// Ticks are handled one at a time.
// Reset (rst, synchronous): clears queues, positions, timers and flags.
// Keyframe memory is undefined after reset and needs no clearing pass.
module servo_keyframe_interpolator #(
  parameter int unsigned CHANNELS_PER_ARM = 4,
  parameter int unsigned QUEUE_DEPTH      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic        arm,
  input  logic [1:0]  channel,
  input  logic [15:0] start_offset,
  input  logic [15:0] stop_offset,
  input  logic [7:0]  target,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  servo_id,
  output logic [7:0]  drive_position,
  output logic [1:0]  moving_flags,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import ski_pkg::*;

  cmd_t        din, cmd;
  logic        avail, take;
  logic [31:0] servo_map;
  logic        rv, rr, rfv;
  logic [3:0]  rs;
  logic [7:0]  rp;
  logic [1:0]  rf;

  assign din = '{op: op_t'(operation), arm: arm, channel: channel,
                 start_offset: start_offset, stop_offset: stop_offset, target: target};
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) servo_map <= MAP_RESET;
    else if (cfg_valid) servo_map <= cfg_data;
  end

  ski_cmd_queue u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .din(din),
    .avail(avail), .take(take), .dout(cmd)
  );

  ski_engine #(
    .CHANNELS_PER_ARM(CHANNELS_PER_ARM), .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk(clk), .rst(rst), .avail(avail), .take(take), .cmd(cmd),
    .servo_map(servo_map), .res_valid(rv), .res_ready(rr), .res_servo(rs),
    .res_pos(rp), .res_flags_valid(rfv), .res_flags(rf)
  );

  ski_result_queue u_out (
    .clk(clk), .rst(rst), .res_valid(rv), .res_ready(rr), .res_servo(rs),
    .res_pos(rp), .res_flags_valid(rfv), .res_flags(rf), .empty(empty),
    .pop(pop), .servo_id(servo_id), .drive_position(drive_position),
    .moving_flags(moving_flags), .last(last)
  );
endmodule

// ===== hw/rtl/ski_cmd_queue.sv =====
`timescale 1ns / 1ps
// Front end: accepts items into a short command queue.
module ski_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  ski_pkg::cmd_t din,
  output logic          avail,
  input  logic          take,
  output ski_pkg::cmd_t dout
);
  import ski_pkg::*;

  cmd_t       slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;

  assign full  = (fill == 3'd4);
  assign avail = (fill != 3'd0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 2'd1;
      if (take && avail) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'b0, push && !full} - {2'b0, take && avail};
    end
  end
endmodule

// ===== hw/rtl/ski_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module ski_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [23:0] quotient
);
  logic [23:0] quo;
  logic [16:0] rem;
  logic [4:0]  bits_left;
  logic        busy;
  logic [16:0] trial;

  assign trial    = {rem[15:0], quo[23]} - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (!trial[16]) begin
        rem <= trial;
        quo <= {quo[22:0], 1'b1};
      end else begin
        rem <= {rem[15:0], quo[23]};
        quo <= {quo[22:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      bits_left <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        bits_left <= 5'd24;
      end else if (busy) begin
        bits_left <= bits_left - 5'd1;
        if (bits_left == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/ski_engine.sv =====
`timescale 1ns / 1ps
// Back end: executes commands, walks channels on a tick and emits positions and moving flags.
module ski_engine #(
  parameter int unsigned CHANNELS_PER_ARM = 4,
  parameter int unsigned QUEUE_DEPTH      = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          avail,
  output logic          take,
  input  ski_pkg::cmd_t cmd,
  input  logic [31:0]   servo_map,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [3:0]    res_servo,
  output logic [7:0]    res_pos,
  output logic          res_flags_valid,
  output logic [1:0]    res_flags
);
  import ski_pkg::*;

  localparam int unsigned NCHAN = 2 * CHANNELS_PER_ARM;
  localparam int unsigned QW    = (NCHAN > 1) ? $clog2(NCHAN) : 1;
  localparam int unsigned CW    = (CHANNELS_PER_ARM > 1) ? $clog2(CHANNELS_PER_ARM) : 1;
  localparam int unsigned HW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW    = $clog2(NCHAN * QUEUE_DEPTH);
  localparam int unsigned KW    = 2 * OFS_W + POS_W;

  logic [KW-1:0]     kf_mem [NCHAN * QUEUE_DEPTH];
  logic [KW-1:0]     kf_rd;
  logic [TIME_W-1:0] tick_count;
  logic [TIME_W-1:0] arm_start [2];
  logic [1:0]        arm_moving;
  logic [1:0]        busy;
  logic [POS_W-1:0]  cur_pos [NCHAN];
  logic [HW-1:0]     q_head [NCHAN];
  logic [NW-1:0]     q_count [NCHAN];

  back_state_t state, state_next;
  logic [QW-1:0] walk;        // walk index; channel q = arm*CPA + c with arm = walk[0], c = walk >> 1
  logic [CW-1:0] walk_c;
  logic          walk_a;
  logic          walk_end;

  // held for emit
  logic [POS_W-1:0] pos_out;
  logic [3:0]       sid_out;

  logic [QW-1:0] push_q;
  logic          ch_ok;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [HW:0]   wr_sum;
  logic [HW-1:0] wr_slot;
  logic [QW-1:0] cur_q;

  logic [OFS_W-1:0]  kf_start, kf_stop;
  logic [POS_W-1:0]  kf_tgt;
  logic [TIME_W-1:0] elapsed;
  logic              begun, reached;
  logic [POS_W-1:0]  diff;
  logic              up;
  logic [OFS_W-1:0]  dur, prog;
  logic [23:0]       product;
  logic              div_start, div_done;
  logic [23:0]       div_q;
  logic              ch_due;
  logic [QW+1:0]     nib;

  assign ch_ok  = ({{(32-2){1'b0}}, cmd.channel} < CHANNELS_PER_ARM);
  assign push_q = QW'(cmd.arm * CHANNELS_PER_ARM + cmd.channel);
  assign walk_c = CW'(walk >> 1);
  assign walk_a = walk[0];
  assign cur_q  = QW'(walk_a * CHANNELS_PER_ARM + walk_c);
  assign walk_end = (walk == QW'(NCHAN - 1));

  // tail slot wraps at the queue depth
  always_comb begin
    wr_sum  = {1'b0, q_head[push_q]} + (HW+1)'(q_count[push_q]);
    wr_slot = (wr_sum >= (HW+1)'(QUEUE_DEPTH)) ? HW'(wr_sum - (HW+1)'(QUEUE_DEPTH))
                                               : wr_sum[HW-1:0];
    wr_addr = AW'(push_q * QUEUE_DEPTH + wr_slot);
    rd_addr = AW'(cur_q * QUEUE_DEPTH + q_head[cur_q]);
  end

  assign {kf_start, kf_stop, kf_tgt} = kf_rd;
  assign elapsed = tick_count - arm_start[walk_a];
  assign begun   = (elapsed >= {16'd0, kf_start});
  assign reached = (elapsed >= {16'd0, kf_stop});
  assign up      = (cur_pos[cur_q] <= kf_tgt);
  assign diff    = up ? kf_tgt - cur_pos[cur_q] : cur_pos[cur_q] - kf_tgt;
  assign dur     = kf_stop - kf_start;
  assign prog    = OFS_W'(elapsed - {16'd0, kf_start});
  assign ch_due  = arm_moving[walk_a] && (q_count[cur_q] != '0);
  assign nib     = {2'b0, cur_q} & (QW+2)'(7);

  // formed from the keyframe read in the cycle before, taken by the divider on start
  assign product = {16'd0, diff} * {8'd0, prog};

  ski_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (dur),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && avail && cmd.op == OP_PUSH && ch_ok
        && q_count[push_q] < NW'(QUEUE_DEPTH))
      kf_mem[wr_addr] <= {cmd.start_offset, cmd.stop_offset, cmd.target};
    if (state == ST_READ) kf_rd <= kf_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (avail && cmd.op == OP_TICK) state_next = ST_READ;
      ST_READ:  state_next = ch_due ? ST_EVAL : (walk_end ? ST_FLAGS : ST_READ);
      ST_EVAL: begin
        if (!begun)       state_next = walk_end ? ST_FLAGS : ST_READ;
        else if (reached) state_next = ST_EMIT;
        else              state_next = ST_DIV;
      end
      ST_DIV:   if (div_done) state_next = ST_EMIT;
      ST_EMIT:  if (res_ready) state_next = walk_end ? ST_FLAGS : ST_READ;
      ST_FLAGS: if (res_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    take            = (state == ST_IDLE) && avail && cmd.op != OP_TICK;
    res_valid       = (state == ST_EMIT);
    res_flags_valid = (state == ST_FLAGS);
    res_servo       = sid_out;
    res_pos         = pos_out;
    res_flags       = arm_moving;
    div_start       = (state == ST_EVAL) && begun && !reached;
    if (state == ST_FLAGS && res_ready) take = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state == ST_EVAL) begin
      sid_out <= servo_map[4*nib[2:0] +: 4];
      if (reached) pos_out <= kf_tgt;
    end
    if (state == ST_DIV && div_done)
      pos_out <= up ? cur_pos[cur_q] + div_q[POS_W-1:0]
                    : cur_pos[cur_q] - div_q[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      arm_start  <= '{default: '0};
      arm_moving <= '0;
      busy       <= '0;
      cur_pos    <= '{default: '0};
      q_head     <= '{default: '0};
      q_count    <= '{default: '0};
      walk       <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (avail) begin
          unique case (cmd.op)
            OP_TICK: begin
              tick_count <= tick_count + 1'b1;
              walk       <= '0;
              busy       <= '0;
            end
            OP_PUSH: if (ch_ok && q_count[push_q] < NW'(QUEUE_DEPTH))
              q_count[push_q] <= q_count[push_q] + 1'b1;
            OP_START: begin
              arm_start[cmd.arm]  <= tick_count;
              arm_moving[cmd.arm] <= 1'b1;
            end
            OP_SET: if (ch_ok) cur_pos[push_q] <= cmd.target;
            default: ;
          endcase
        end
        ST_READ: begin
          if (ch_due) busy[walk_a] <= 1'b1;
          else if (!walk_end) walk <= walk + 1'b1;
        end
        ST_EVAL: begin
          if (!begun && !walk_end) walk <= walk + 1'b1;
          if (begun && reached) begin
            cur_pos[cur_q] <= kf_tgt;
            q_head[cur_q]  <= (q_head[cur_q] == HW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : q_head[cur_q] + 1'b1;
            q_count[cur_q] <= q_count[cur_q] - 1'b1;
          end
          if (!begun && walk_end) arm_moving <= arm_moving & busy;
        end
        ST_EMIT: if (res_ready && !walk_end) walk <= walk + 1'b1;
        default: ;
      endcase
      // flags settle once the walk ends
      if ((state == ST_READ && !ch_due && walk_end) ||
          (state == ST_EMIT && res_ready && walk_end))
        arm_moving <= arm_moving & busy;
    end
  end
endmodule

// ===== hw/rtl/ski_result_queue.sv =====
`timescale 1ns / 1ps
// Result buffer: gathers one tick's results, patches flags, releases them.
module ski_result_queue (
  input  logic       clk,
  input  logic       rst,
  input  logic       res_valid,
  output logic       res_ready,
  input  logic [3:0] res_servo,
  input  logic [7:0] res_pos,
  input  logic       res_flags_valid,
  input  logic [1:0] res_flags,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] servo_id,
  output logic [7:0] drive_position,
  output logic [1:0] moving_flags,
  output logic       last
);
  logic [11:0] buf_q [8];
  logic [3:0]  wcnt;
  logic [2:0]  rptr;
  logic [1:0]  flags;
  logic        draining;

  assign res_ready      = !draining;
  assign empty          = !draining;
  assign servo_id       = buf_q[rptr][11:8];
  assign drive_position = buf_q[rptr][7:0];
  assign moving_flags   = flags;
  assign last           = ({1'b0, rptr} == wcnt - 4'd1);

  always_ff @(posedge clk) begin
    if (res_valid && !draining) buf_q[wcnt[2:0]] <= {res_servo, res_pos};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt     <= '0;
      rptr     <= '0;
      draining <= 1'b0;
      flags    <= '0;
    end else if (!draining) begin
      if (res_valid) wcnt <= wcnt + 4'd1;
      // hold results until the tick's flags are known
      if (res_flags_valid) begin
        flags    <= res_flags;
        rptr     <= '0;
        draining <= (wcnt != 4'd0);
      end
    end else if (pop) begin
      rptr <= rptr + 3'd1;
      if (last) begin
        draining <= 1'b0;
        wcnt     <= '0;
      end
    end
  end
endmodule
